// ===== rtl/i2a_pkg.sv =====
// shared types, character codes and digit encoding for the radix text converter
`default_nettype none

package i2a_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [5:0] DIGIT_MAX  = 6'd9;
  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam int         STEP_BITS  = 4;
  localparam int         RADIX_W    = 6;
  localparam int         CHAR_W     = 8;
  localparam int         LEN_W      = 6;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_SIGN  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_SEND  = 5'b10000
  } i2a_state_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d > DIGIT_MAX) begin
      c = CHAR_A + {2'b00, d} - 8'd10;
    end else begin
      c = CHAR_ZERO + {2'b00, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2a_front.sv =====
// front end: takes input words, clamps the radix, forms sign and magnitude, queues jobs
`default_nettype none

module i2a_front
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_kind,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic [RADIX_W-1:0]     in_radix,
  output logic                        job_valid,
  input  wire logic                   job_ready,
  output logic                        job_neg,
  output logic [RADIX_W-1:0]          job_radix,
  output logic [VALUE_WIDTH-1:0]      job_mag
);

  localparam int QW = 1 + RADIX_W + VALUE_WIDTH;

  logic [QW-1:0]          q_r [2];
  logic                   wr_r, wr_nxt;
  logic                   rd_r, rd_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   neg;
  logic [RADIX_W-1:0]     rad;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   push, pop;

  always_comb begin
    if (in_radix inside {[6'd0:6'd1]}) begin
      rad = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      rad = RADIX_MAX;
    end else begin
      rad = in_radix;
    end
    neg = in_kind & in_value[VALUE_WIDTH-1];
    mag = neg ? (~in_value + 1'b1) : in_value;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid & in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid & job_ready;
  assign {job_neg, job_radix, job_mag} = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r ^ push;
    rd_nxt  = rd_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= {neg, rad, mag};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2a_back.sv =====
// back end: repeated division by the radix into a digit stack, then text output
`default_nettype none

module i2a_back
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   job_valid,
  output logic                        job_ready,
  input  wire logic                   job_neg,
  input  wire logic [RADIX_W-1:0]     job_radix,
  input  wire logic [VALUE_WIDTH-1:0] job_mag,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CHAR_W-1:0]           out_char,
  output logic [LEN_W-1:0]            out_len,
  output logic                        out_last
);

  localparam int NSTEP = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PW    = NSTEP * STEP_BITS;
  localparam int SW    = $clog2(NSTEP);
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int CW    = $clog2(VALUE_WIDTH + 1);
  localparam int LW    = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;

  i2a_state_t         state_r, state_nxt;
  logic [PW-1:0]      div_r, div_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] rad_r, rad_nxt;
  logic [SW-1:0]      sc_r, sc_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic               neg_r, neg_nxt;
  logic               ov_r, ov_nxt;
  logic [CHAR_W-1:0]  oc_r, oc_nxt;
  logic [LEN_W-1:0]   ol_r, ol_nxt;
  logic               olast_r, olast_nxt;

  logic [RADIX_W-1:0] stack_mem [VALUE_WIDTH];
  logic [RADIX_W-1:0] rd_data_r;

  logic [RADIX_W-1:0]   rem_v;
  logic [RADIX_W:0]     trial;
  logic [STEP_BITS-1:0] quo_v;
  logic [PW-1:0]        div_shift;
  logic                 last_step;
  logic                 push;
  logic                 load_en;
  logic [LW-1:0]        len_full;

  always_comb begin
    rem_v = rem_r;
    quo_v = '0;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_v, div_r[PW-1-i]};
      if (trial >= {1'b0, rad_r}) begin
        trial = trial - {1'b0, rad_r};
        quo_v[STEP_BITS-1-i] = 1'b1;
      end
      rem_v = trial[RADIX_W-1:0];
    end
    div_shift = {div_r[PW-STEP_BITS-1:0], quo_v};
  end

  assign last_step = (sc_r == SW'(NSTEP - 1));
  assign push      = (state_r == ST_DIV) && last_step;
  assign load_en   = !ov_r || out_ready;
  assign len_full  = LW'(cnt_r) + LW'(neg_r);
  assign job_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    rad_nxt   = rad_r;
    sc_nxt    = sc_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r & ~out_ready;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    olast_nxt = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          div_nxt   = PW'(job_mag);
          rem_nxt   = '0;
          rad_nxt   = job_radix;
          sc_nxt    = '0;
          cnt_nxt   = '0;
          neg_nxt   = job_neg;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_nxt = div_shift;
        if (last_step) begin
          cnt_nxt = cnt_r + 1'b1;
          ptr_nxt = cnt_r[AW-1:0];
          rem_nxt = '0;
          sc_nxt  = '0;
          if (div_shift == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_FETCH;
          end
        end else begin
          rem_nxt = rem_v;
          sc_nxt  = sc_r + 1'b1;
        end
      end
      ST_SIGN: begin
        if (load_en) begin
          ov_nxt    = 1'b1;
          oc_nxt    = CHAR_MINUS;
          ol_nxt    = len_full[LEN_W-1:0];
          olast_nxt = 1'b0;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (load_en) begin
          ov_nxt    = 1'b1;
          oc_nxt    = digit_char(rd_data_r);
          ol_nxt    = len_full[LEN_W-1:0];
          olast_nxt = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r - 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      sc_r    <= '0;
      cnt_r   <= '0;
      ptr_r   <= '0;
      neg_r   <= 1'b0;
      rad_r   <= RADIX_MIN;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      sc_r    <= sc_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      neg_r   <= neg_nxt;
      rad_r   <= rad_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    oc_r    <= oc_nxt;
    ol_r    <= ol_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[cnt_r[AW-1:0]] <= rem_v;
    end
    rd_data_r <= stack_mem[ptr_r];
  end

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_len   = ol_r;
  assign out_last  = olast_r;

  a_job_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |=> state_r == ST_DIV)
    else $error("accepted job did not start division");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(VALUE_WIDTH))
    else $error("digit count beyond value width");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < rad_r)
    else $error("partial remainder not below radix");

  a_final_marked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND && load_en && ptr_r == '0 |=> out_last && out_valid)
    else $error("final digit not marked last");

endmodule

`default_nettype wire

// ===== rtl/integer_to_radix_ascii.sv =====
// top level of the integer to radix text converter with stream ports
`default_nettype none

// Converts a signed or unsigned integer to lower-case text in radix 2 to 36, most
// significant digit first, one character per output word, with a leading '-' for a
// negative signed value and a single '0' for zero. The radix saturates to 2..36.
// Every word carries the total text length; tlast marks the final character.
// Each digit is formed in the shared remainder unit, which retires four quotient bits
// a cycle, and is then sent through the digit stack read port (states ST_FETCH and
// ST_SEND); a negative value adds the ST_SIGN state for the '-', and ST_IDLE takes
// the job.
// A two-entry job queue keeps accepting input words while a conversion runs, until full.
module integer_to_radix_ascii
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // value, radix, zero pad
  input  wire logic [((VALUE_WIDTH+RADIX_W+7)/8)*8-1:0] in_tdata,
  // kind
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // character, text_length, zero pad
  output logic [15:0]                out_tdata,
  output logic                       out_tlast
);

  logic                   job_valid;
  logic                   job_ready;
  logic                   job_neg;
  logic [RADIX_W-1:0]     job_radix;
  logic [VALUE_WIDTH-1:0] job_mag;
  logic [CHAR_W-1:0]      out_char;
  logic [LEN_W-1:0]       out_len;

  i2a_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .in_radix  (in_tdata[VALUE_WIDTH+RADIX_W-1:VALUE_WIDTH]),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_neg   (job_neg),
    .job_radix (job_radix),
    .job_mag   (job_mag)
  );

  i2a_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_neg   (job_neg),
    .job_radix (job_radix),
    .job_mag   (job_mag),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_len   (out_len),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_len, out_char};

endmodule

`default_nettype wire

// ===== tb/tb_integer_to_radix_ascii.sv =====
// self-checking testbench for the integer to radix text converter
`timescale 1ns / 100ps

module tb_integer_to_radix_ascii
  import i2a_pkg::*;
();

  localparam int VALUE_W     = 32;
  localparam int DATA_W      = ((VALUE_W + RADIX_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 400;
  localparam int RANDOM_ITEMS = 138;

  localparam logic KIND_UNSIGNED = 1'b0;
  localparam logic KIND_SIGNED   = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              last;
  } char_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic              out_tlast;

  char_word_t expected_chars[$];
  int         error_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         quiet_cycles = 0;

  integer_to_radix_ascii #(
    .VALUE_WIDTH(VALUE_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic predict_text(input logic kind, input logic [VALUE_W-1:0] value,
                              input logic [RADIX_W-1:0] radix);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [CHAR_W-1:0]  digits[$];
    logic [RADIX_W-1:0] d;
    logic               neg;
    int                 total;
    char_word_t         w;
    if (radix < RADIX_MIN) begin
      base = VALUE_W'(RADIX_MIN);
    end else if (radix > RADIX_MAX) begin
      base = VALUE_W'(RADIX_MAX);
    end else begin
      base = VALUE_W'(radix);
    end
    neg = (kind == KIND_SIGNED) && value[VALUE_W-1];
    mag = neg ? (~value + 1'b1) : value;
    do begin
      d = RADIX_W'(mag % base);
      if (d > DIGIT_MAX) begin
        digits.push_front(CHAR_A + {2'b00, d} - 8'd10);
      end else begin
        digits.push_front(CHAR_ZERO + {2'b00, d});
      end
      mag = mag / base;
    end while (mag != 0);
    total = digits.size() + (neg ? 1 : 0);
    if (neg) begin
      w.ch = CHAR_MINUS;
      w.len = LEN_W'(total);
      w.last = (total == 1);
      expected_chars.push_back(w);
    end
    for (int i = 0; i < digits.size(); i++) begin
      w.ch = digits[i];
      w.len = LEN_W'(total);
      w.last = (i == digits.size() - 1);
      expected_chars.push_back(w);
    end
  endtask

  task automatic send_word(input logic kind, input logic [VALUE_W-1:0] value,
                           input logic [RADIX_W-1:0] radix);
    in_tdata <= {{(DATA_W - VALUE_W - RADIX_W){1'b0}}, radix, value};
    in_tuser <= kind;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_text(kind, value, radix);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic test_zero();
    send_word(KIND_UNSIGNED, 32'd0, 6'd10);
    send_word(KIND_SIGNED, 32'd0, 6'd2);
    send_word(KIND_SIGNED, 32'd0, 6'd36);
  endtask

  task automatic test_extremes();
    send_word(KIND_UNSIGNED, 32'hFFFF_FFFF, 6'd2);
    send_word(KIND_SIGNED, 32'hFFFF_FFFF, 6'd10);
    send_word(KIND_SIGNED, 32'h8000_0000, 6'd2);
    send_word(KIND_SIGNED, 32'h8000_0000, 6'd36);
    send_word(KIND_UNSIGNED, 32'h8000_0000, 6'd10);
    send_word(KIND_SIGNED, 32'h7FFF_FFFF, 6'd16);
    send_word(KIND_UNSIGNED, 32'hFFFF_FFFF, 6'd36);
    send_word(KIND_UNSIGNED, 32'd1, 6'd2);
  endtask

  task automatic test_radix_clamp();
    send_word(KIND_UNSIGNED, 32'd37, 6'd0);
    send_word(KIND_SIGNED, 32'hFFFF_FFF6, 6'd1);
    send_word(KIND_UNSIGNED, 32'd12345, 6'd37);
    send_word(KIND_SIGNED, 32'hFFFF_FF00, 6'd63);
  endtask

  task automatic test_letter_digits();
    send_word(KIND_UNSIGNED, 32'd9, 6'd10);
    send_word(KIND_UNSIGNED, 32'd10, 6'd11);
    send_word(KIND_UNSIGNED, 32'd35, 6'd36);
    send_word(KIND_UNSIGNED, 32'hDEAD_BEEF, 6'd16);
    send_word(KIND_SIGNED, 32'hCAFE_F00D, 6'd8);
    send_word(KIND_UNSIGNED, 32'd36, 6'd36);
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct);
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    int                 sh;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sh = $urandom_range(0, VALUE_W - 1);
      case ($urandom_range(0, 4))
        0: value = $urandom();
        1: value = $urandom_range(0, 40);
        2: value = 32'd1 << sh;
        3: value = (32'd1 << sh) - 1'b1;
        default: value = 32'h8000_0000 + $urandom_range(0, 8) - 4;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        radix = RADIX_W'($urandom_range(0, 63));
      end else begin
        radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      end
      send_word(1'($urandom_range(0, 1)), value, radix);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    char_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected word: char %h len %0d last %b",
                   out_tdata[7:0], out_tdata[13:8], out_tlast);
        end
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[7:0] !== want.ch || out_tdata[13:8] !== want.len ||
            out_tlast !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected char %h len %0d last %b, got char %h len %0d last %b",
                     want.ch, want.len, want.last, out_tdata[7:0], out_tdata[13:8],
                     out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero();
    test_extremes();
    test_radix_clamp();
    test_letter_digits();
    test_random(20, 75);
    test_random(75, 20);
    test_random(0, 0);
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_chars.size() != 0) begin
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
